// ----- hw/rtl/omp_pkg.sv -----
`timescale 1ns / 1ps

package omp_pkg;

	localparam int MAX_TAGS   = 32;
	localparam int MAX_PACKET = 2048;

	localparam int TAG_IDX_W = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;
	localparam int TAG_CNT_W = $clog2(MAX_TAGS + 1);
	localparam int POS_W     = $clog2(MAX_PACKET + 1);

	// One input byte can cause at most this many results.
	localparam int RES_SLOTS  = 3;
	localparam int SLOT_CNT_W = 2;

	// The result queue depth must be a power of two.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [1:0] KIND_ADDR   = 2'd0;
	localparam logic [1:0] KIND_ARG    = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [1:0] REASON_NONE  = 2'd0;
	localparam logic [1:0] REASON_SHORT = 2'd1;
	localparam logic [1:0] REASON_ADDR  = 2'd2;
	localparam logic [1:0] REASON_TAGS  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] word;
		logic        arg_is_int;
		logic [4:0]  arg_number;
		logic [1:0]  reject_reason;
		logic        run_last;
	} result_t;

	typedef struct packed {
		logic [SLOT_CNT_W-1:0]       count;
		result_t [RES_SLOTS-1:0]     slot;
	} push_t;

endpackage

// ----- hw/rtl/omp_result_queue.sv -----
`timescale 1ns / 1ps

module omp_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  omp_pkg::push_t   push,
	output logic             room,
	output logic             valid,
	input  logic             ready,
	output omp_pkg::result_t head
);
	import omp_pkg::*;

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];
	assign pop   = valid && ready;
	// Room is judged on the current fill alone, so input ready never waits on output ready.
	assign room  = (cnt_q <= QCNT_W'(QUEUE_DEPTH - RES_SLOTS));

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_SLOTS; i++) begin
			if (SLOT_CNT_W'(i) < push.count) begin
				mem_q[wr_q + QPTR_W'(i)] <= push.slot[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.count);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

// ----- hw/rtl/omp_parse_engine.sv -----
`timescale 1ns / 1ps

module omp_parse_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  omp_pkg::byte_item_t item,
	output omp_pkg::push_t      push
);
	import omp_pkg::*;

	typedef enum logic [2:0] {
		PH_START, PH_ADDR, PH_APAD, PH_TAGS, PH_TPAD, PH_ARGS, PH_BADADDR, PH_BADTAGS
	} phase_t;

	typedef enum logic [1:0] {DT_F, DT_I, DT_D, DT_S} dtag_t;

	// Only data tags are stored, each with the number of non-d data tags before it.
	// For a d entry that number indexes the first f, i or s that follows it.
	typedef struct packed {
		dtag_t                code;
		logic [TAG_CNT_W-1:0] rank;
	} dentry_t;

	function automatic result_t make_result(logic [1:0] kind, logic [31:0] word,
			logic is_int, logic [4:0] num, logic [1:0] reason);
		result_t r;
		r.kind          = kind;
		r.word          = word;
		r.arg_is_int    = is_int;
		r.arg_number    = num;
		r.reject_reason = reason;
		r.run_last      = 1'b0;
		return r;
	endfunction

	phase_t               phase_q, phase_n;
	logic [POS_W-1:0]     pos_q, pos_n;
	logic [TAG_CNT_W-1:0] tag_cnt_q, tag_cnt_n;
	logic [TAG_CNT_W-1:0] dcnt_q, dcnt_n;
	logic [TAG_CNT_W-1:0] ndcnt_q, ndcnt_n;
	logic [TAG_CNT_W-1:0] cursor_q, cursor_n;
	logic [31:0]          hold_q, hold_n;
	logic [2:0]           hc_q, hc_n;
	logic [4:0]           args_q, args_n;
	dentry_t              cur_q, cur_n;
	dentry_t              nxt_q, nxt_n;

	dentry_t              dstore_q [MAX_TAGS];
	dtag_t                ndstore_q [MAX_TAGS];
	logic                 d_we, nd_we;
	dentry_t              d_wentry;

	logic [TAG_CNT_W-1:0] rd_sum;
	logic [TAG_IDX_W-1:0] rd_idx;

	assign rd_sum = cursor_q + TAG_CNT_W'(2);
	assign rd_idx = rd_sum[TAG_IDX_W-1:0];

	always_comb begin
		logic [7:0]            b;
		logic                  is_data;
		dtag_t                 code;
		logic [SLOT_CNT_W-1:0] n;
		logic                  arg_go;
		logic                  adv;
		logic                  seen;
		logic [31:0]           full_word;
		logic [31:0]           shifted;
		logic [1:0]            reason;
		dtag_t                 nd_look;

		b         = item.data_byte;
		n         = '0;
		arg_go    = 1'b0;
		adv       = 1'b0;
		seen      = 1'b0;
		reason    = REASON_NONE;
		nd_look   = DT_F;
		full_word = {hold_q[7:0], hold_q[15:8], hold_q[23:16], b};
		shifted   = 32'(b) << {hc_q[1:0], 3'b000};

		is_data = 1'b1;
		code    = DT_F;
		unique case (b)
			CH_F:    code = DT_F;
			CH_I:    code = DT_I;
			CH_D:    code = DT_D;
			CH_S:    code = DT_S;
			default: is_data = 1'b0;
		endcase

		phase_n   = phase_q;
		pos_n     = pos_q;
		tag_cnt_n = tag_cnt_q;
		dcnt_n    = dcnt_q;
		ndcnt_n   = ndcnt_q;
		cursor_n  = cursor_q;
		hold_n    = hold_q;
		hc_n      = hc_q;
		args_n    = args_q;
		cur_n     = cur_q;
		nxt_n     = nxt_q;
		d_we      = 1'b0;
		nd_we     = 1'b0;
		d_wentry.code = code;
		d_wentry.rank = ndcnt_q;
		push      = '0;

		if (fire) begin
			// Bytes past the packet limit are dropped, but a final mark on them still counts.
			if (pos_q < POS_W'(MAX_PACKET)) begin
				pos_n = pos_q + 1'b1;
				unique case (phase_q)
					PH_START: begin
						if (b == CH_SLASH) begin
							push.slot[n] = make_result(KIND_ADDR, {24'd0, b}, 1'b0, 5'd0,
								REASON_NONE);
							n = n + 1'b1;
							phase_n = PH_ADDR;
						end else begin
							phase_n = PH_BADADDR;
						end
					end
					PH_ADDR: begin
						if (b != CH_NUL) begin
							push.slot[n] = make_result(KIND_ADDR, {24'd0, b}, 1'b0, 5'd0,
								REASON_NONE);
							n = n + 1'b1;
						end else begin
							phase_n = PH_APAD;
						end
					end
					PH_APAD: begin
						if (pos_q[1:0] == 2'd0) begin
							phase_n = (b == CH_COMMA) ? PH_TAGS : PH_BADTAGS;
						end
					end
					PH_TAGS: begin
						if (b == CH_NUL) begin
							phase_n = PH_TPAD;
						end else if (tag_cnt_q < TAG_CNT_W'(MAX_TAGS)) begin
							tag_cnt_n = tag_cnt_q + 1'b1;
							if (is_data) begin
								d_we   = 1'b1;
								dcnt_n = dcnt_q + 1'b1;
								if (dcnt_q == '0) begin
									cur_n = d_wentry;
								end
								if (dcnt_q == TAG_CNT_W'(1)) begin
									nxt_n = d_wentry;
								end
								if (code != DT_D) begin
									nd_we   = 1'b1;
									ndcnt_n = ndcnt_q + 1'b1;
								end
							end
						end
					end
					PH_TPAD: begin
						// The cursor is already at the first data tag here.
						if (pos_q[1:0] == 2'd0) begin
							phase_n = PH_ARGS;
							arg_go  = 1'b1;
						end
					end
					PH_ARGS: arg_go = 1'b1;
					default: ;
				endcase

				if (arg_go && (cursor_q < dcnt_q)) begin
					unique case (cur_q.code)
						DT_F, DT_I: begin
							if (hc_q == 3'd3) begin
								push.slot[n] = make_result(KIND_ARG, full_word,
									cur_q.code == DT_I, args_q, REASON_NONE);
								n      = n + 1'b1;
								args_n = args_q + 1'b1;
								adv    = 1'b1;
							end else begin
								hold_n = hold_q | shifted;
								hc_n   = hc_q + 1'b1;
							end
						end
						DT_D: begin
							if (hc_q == 3'd7) begin
								adv = 1'b1;
							end else begin
								// Only the first four bytes of a double are ever looked at.
								if (!hc_q[2]) begin
									hold_n = hold_q | shifted;
								end
								hc_n = hc_q + 1'b1;
							end
						end
						DT_S: begin
							if (hc_q == 3'd3) begin
								seen = (hold_q[7:0] == CH_NUL) || (hold_q[15:8] == CH_NUL) ||
									(hold_q[23:16] == CH_NUL) || (b == CH_NUL);
								if (seen) begin
									adv = 1'b1;
								end else begin
									hold_n = '0;
									hc_n   = '0;
								end
							end else begin
								hold_n = hold_q | shifted;
								hc_n   = hc_q + 1'b1;
							end
						end
						default: ;
					endcase
					if (adv) begin
						cursor_n = cursor_q + 1'b1;
						hold_n   = '0;
						hc_n     = '0;
						cur_n    = nxt_q;
						nxt_n    = dstore_q[rd_idx];
					end
				end
			end

			if (item.final_byte) begin
				if (pos_n < POS_W'(8)) begin
					reason = REASON_SHORT;
				end else if (phase_n == PH_ADDR || phase_n == PH_BADADDR ||
						phase_n == PH_START) begin
					reason = REASON_ADDR;
				end else if (phase_n == PH_APAD || phase_n == PH_TAGS ||
						phase_n == PH_BADTAGS) begin
					reason = REASON_TAGS;
				end

				if (reason != REASON_NONE) begin
					push.slot[n] = make_result(KIND_REJECT, 32'd0, 1'b0, 5'd0, reason);
					n = n + 1'b1;
				end else begin
					// A double cut short leaves four held bytes; the next f or i
					// after it, unless an s comes first, reads them.
					nd_look = ndstore_q[cur_n.rank[TAG_IDX_W-1:0]];
					if (phase_n == PH_ARGS && cursor_n < dcnt_n && cur_n.code == DT_D &&
							hc_n[2] && cur_n.rank < ndcnt_n &&
							(nd_look == DT_F || nd_look == DT_I)) begin
						push.slot[n] = make_result(KIND_ARG,
							{hold_n[7:0], hold_n[15:8], hold_n[23:16], hold_n[31:24]},
							nd_look == DT_I, args_n, REASON_NONE);
						n = n + 1'b1;
					end
					push.slot[n] = make_result(KIND_ACCEPT, 32'd0, 1'b0, 5'd0, REASON_NONE);
					n = n + 1'b1;
				end

				phase_n   = PH_START;
				pos_n     = '0;
				tag_cnt_n = '0;
				dcnt_n    = '0;
				ndcnt_n   = '0;
				cursor_n  = '0;
				hold_n    = '0;
				hc_n      = '0;
				args_n    = '0;
			end

			if (n != '0) begin
				push.slot[n - 1'b1].run_last = 1'b1;
			end
			push.count = n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_n;
		nxt_q <= nxt_n;
		if (d_we) begin
			dstore_q[dcnt_q[TAG_IDX_W-1:0]] <= d_wentry;
		end
		if (nd_we) begin
			ndstore_q[ndcnt_q[TAG_IDX_W-1:0]] <= d_wentry.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			pos_q     <= '0;
			tag_cnt_q <= '0;
			dcnt_q    <= '0;
			ndcnt_q   <= '0;
			cursor_q  <= '0;
			hold_q    <= '0;
			hc_q      <= '0;
			args_q    <= '0;
		end else begin
			phase_q   <= phase_n;
			pos_q     <= pos_n;
			tag_cnt_q <= tag_cnt_n;
			dcnt_q    <= dcnt_n;
			ndcnt_q   <= ndcnt_n;
			cursor_q  <= cursor_n;
			hold_q    <= hold_n;
			hc_q      <= hc_n;
			args_q    <= args_n;
		end
	end

endmodule

// ----- hw/rtl/osc_message_parser_core.sv -----
`timescale 1ns / 1ps

// Byte-serial parser for one message packet: takes one packet byte per cycle and
// emits address characters, 32-bit argument words, and a closing accept or reject
// item. A byte is taken into an input register and parsed from there once the result
// queue has room; its results land in that four-entry queue, which drives the outputs.
// Throughput is one byte per cycle as long as the results are taken as they come and
// each byte yields at most one result; the final byte of a packet can yield two, and
// the input then holds while the queue drains. The parser only fires when the queue
// has room for three results. There is no clearing pass after reset; the type tag
// store is valid only where written.

module osc_message_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  omp_pkg::byte_item_t byte_item,
	output logic                result_valid,
	input  logic                result_ready,
	output omp_pkg::result_t    result_item
);
	import omp_pkg::*;

	byte_item_t item_s1;
	logic       valid_s1;
	logic       room;
	logic       fire;
	push_t      push;

	assign fire       = valid_s1 && room;
	assign byte_ready = !valid_s1 || fire;

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	omp_parse_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.push   (push)
	);

	omp_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (result_valid),
		.ready  (result_ready),
		.head   (result_item)
	);

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import omp_pkg::*;

	localparam int RANDOM_ITEMS = 360;
	localparam int QUIET_LIMIT  = 200;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [2:0] {
		ST_START, ST_ADDR, ST_ADDR_PAD, ST_TAGS, ST_TAG_PAD, ST_ARGS, ST_BAD_ADDR, ST_BAD_TAGS
	} stage_t;

	typedef struct {
		logic [7:0] data;
		logic       fin;
		bit         typed;
		result_t    want;
	} directed_row_t;

	localparam result_t NO_RESULT    = '0;
	localparam result_t SHORT_REJECT = {KIND_REJECT, 32'd0, 1'b0, 5'd0, REASON_SHORT, 1'b1};
	localparam result_t ADDR_REJECT  = {KIND_REJECT, 32'd0, 1'b0, 5'd0, REASON_ADDR, 1'b1};
	localparam result_t SLASH_ECHO   = {KIND_ADDR, {24'd0, CH_SLASH}, 1'b0, 5'd0, REASON_NONE, 1'b1};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_ready;
	byte_item_t byte_item = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	result_t    result_item;

	bit      failed = 1'b0;
	bit      idle_on = 1'b0;
	int      quiet_cycles = 0;
	result_t pending_results[$];
	result_t byte_results[$];
	logic [7:0] pkt[$];
	int      comma_at;

	// Parser state mirrored for prediction.
	stage_t      stage;
	int unsigned rx_pos;
	logic [7:0]  tag_list[MAX_TAGS];
	int unsigned tags_held;
	int unsigned tag_at;
	logic [63:0] arg_bytes;
	int unsigned arg_fill;
	int unsigned arg_index;

	// A lone zero byte is both short and missing its slash; the short reason wins.
	directed_row_t directed_rows[25] = '{
		'{8'h00, 1'b1, 1'b1, SHORT_REJECT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b1, 1'b1, ADDR_REJECT},
		'{CH_SLASH, 1'b0, 1'b1, SLASH_ECHO},
		'{8'h61, 1'b0, 1'b0, NO_RESULT},
		'{CH_NUL, 1'b0, 1'b0, NO_RESULT},
		'{CH_NUL, 1'b0, 1'b0, NO_RESULT},
		'{CH_COMMA, 1'b0, 1'b0, NO_RESULT},
		'{CH_I, 1'b0, 1'b0, NO_RESULT},
		'{CH_F, 1'b0, 1'b0, NO_RESULT},
		'{CH_NUL, 1'b0, 1'b0, NO_RESULT},
		'{8'h80, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, 1'b0, NO_RESULT},
		'{8'h01, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, 1'b0, NO_RESULT},
		'{8'hFF, 1'b1, 1'b0, NO_RESULT}
	};

	osc_message_parser_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_parser();
		stage     = ST_START;
		rx_pos    = 0;
		tags_held = 0;
		tag_at    = 0;
		arg_bytes = '0;
		arg_fill  = 0;
		arg_index = 0;
	endfunction

	function automatic void add_byte(logic [7:0] b);
		pkt = {pkt, b};
	endfunction

	function automatic void add_result(logic [1:0] kind, logic [31:0] word, logic is_int,
			int unsigned num, logic [1:0] reason);
		result_t r;
		r.kind          = kind;
		r.word          = word;
		r.arg_is_int    = is_int;
		r.arg_number    = 5'(num);
		r.reject_reason = reason;
		r.run_last      = 1'b0;
		byte_results = {byte_results, r};
	endfunction

	function automatic logic [31:0] arg_word();
		return {arg_bytes[7:0], arg_bytes[15:8], arg_bytes[23:16], arg_bytes[31:24]};
	endfunction

	function automatic bit carries_data(logic [7:0] t);
		return t == CH_F || t == CH_I || t == CH_D || t == CH_S;
	endfunction

	function automatic void skip_plain_tags();
		while (tag_at < tags_held && !carries_data(tag_list[tag_at]))
			tag_at++;
	endfunction

	function automatic void advance_tag();
		tag_at++;
		arg_bytes = '0;
		arg_fill  = 0;
		skip_plain_tags();
	endfunction

	function automatic void take_arg_byte(logic [7:0] b);
		logic [7:0] t;
		skip_plain_tags();
		if (tag_at >= tags_held)
			return;
		t = tag_list[tag_at];
		arg_bytes |= 64'(b) << (8 * (arg_fill % 8));
		arg_fill++;
		if (t == CH_F || t == CH_I) begin
			if (arg_fill >= 4) begin
				add_result(KIND_ARG, arg_word(), t == CH_I, arg_index, REASON_NONE);
				arg_index++;
				advance_tag();
			end
		end else if (t == CH_D) begin
			if (arg_fill >= 8)
				advance_tag();
		end else if (arg_fill >= 4) begin
			// A string ends in the first four-byte chunk that holds a zero byte.
			if (arg_bytes[7:0] == 0 || arg_bytes[15:8] == 0 || arg_bytes[23:16] == 0 ||
					arg_bytes[31:24] == 0)
				advance_tag();
			else begin
				arg_bytes = '0;
				arg_fill  = 0;
			end
		end
	endfunction

	// Works out the results that one packet byte causes, in order.
	function automatic void parse_byte(byte_item_t it);
		logic [7:0]  b;
		int unsigned p;
		int unsigned c;
		logic [1:0]  reason;
		bit          done;
		b = it.data_byte;
		byte_results.delete();
		if (rx_pos < MAX_PACKET) begin
			p = rx_pos;
			rx_pos++;
			case (stage)
				ST_START: begin
					if (b == CH_SLASH) begin
						add_result(KIND_ADDR, {24'd0, b}, 1'b0, 0, REASON_NONE);
						stage = ST_ADDR;
					end else
						stage = ST_BAD_ADDR;
				end
				ST_ADDR: begin
					if (b != CH_NUL)
						add_result(KIND_ADDR, {24'd0, b}, 1'b0, 0, REASON_NONE);
					else
						stage = ST_ADDR_PAD;
				end
				ST_ADDR_PAD: begin
					if (p % 4 == 0)
						stage = (b == CH_COMMA) ? ST_TAGS : ST_BAD_TAGS;
				end
				ST_TAGS: begin
					if (b == CH_NUL)
						stage = ST_TAG_PAD;
					else if (tags_held < MAX_TAGS) begin
						tag_list[tags_held] = b;
						tags_held++;
					end
				end
				ST_TAG_PAD: begin
					if (p % 4 == 0) begin
						stage  = ST_ARGS;
						tag_at = 0;
						take_arg_byte(b);
					end
				end
				ST_ARGS: take_arg_byte(b);
				default: ;
			endcase
		end
		if (it.final_byte) begin
			reason = REASON_NONE;
			if (rx_pos < 8)
				reason = REASON_SHORT;
			else if (stage inside {ST_ADDR, ST_BAD_ADDR, ST_START})
				reason = REASON_ADDR;
			else if (stage inside {ST_ADDR_PAD, ST_TAGS, ST_BAD_TAGS})
				reason = REASON_TAGS;
			if (reason != REASON_NONE)
				add_result(KIND_REJECT, 32'd0, 1'b0, 0, reason);
			else begin
				// A cut-short d leaves its first four bytes to a later f or i, unless an s
				// comes first.
				if (stage == ST_ARGS && tag_at < tags_held && tag_list[tag_at] == CH_D &&
						arg_fill >= 4) begin
					c    = tag_at + 1;
					done = 1'b0;
					while (c < tags_held && !done) begin
						if (tag_list[c] == CH_F || tag_list[c] == CH_I) begin
							add_result(KIND_ARG, arg_word(), tag_list[c] == CH_I, arg_index,
								REASON_NONE);
							done = 1'b1;
						end else if (tag_list[c] == CH_S)
							done = 1'b1;
						c++;
					end
				end
				add_result(KIND_ACCEPT, 32'd0, 1'b0, 0, REASON_NONE);
			end
			clear_parser();
		end
		if (byte_results.size() > 0)
			byte_results[byte_results.size() - 1].run_last = 1'b1;
	endfunction

	task automatic send_byte(input byte_item_t it, input bit typed, input result_t want);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		parse_byte(it);
		if (typed)
			pending_results = {pending_results, want};
		else
			foreach (byte_results[k])
				pending_results = {pending_results, byte_results[k]};
	endtask

	task automatic send_packet();
		byte_item_t it;
		foreach (pkt[k]) begin
			it.data_byte  = pkt[k];
			it.final_byte = (k == pkt.size() - 1);
			send_byte(it, 1'b0, NO_RESULT);
		end
	endtask

	function automatic logic [7:0] any_but(logic [7:0] c);
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == c);
		return b;
	endfunction

	function automatic void pad_to_word();
		while (pkt.size() % 4 != 0)
			add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_NUL);
	endfunction

	function automatic logic [7:0] pick_tag();
		case ($urandom_range(0, 11))
			0, 1, 2: return CH_F;
			3, 4, 5: return CH_I;
			6, 7:    return CH_D;
			8, 9:    return CH_S;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic void add_arg_data(logic [7:0] t);
		if (t == CH_F || t == CH_I)
			repeat (4) add_byte(8'($urandom_range(0, 255)));
		else if (t == CH_D)
			repeat (8) add_byte(8'($urandom_range(0, 255)));
		else if (t == CH_S) begin
			repeat ($urandom_range(0, 9)) add_byte(8'($urandom_range(1, 255)));
			add_byte(CH_NUL);
			pad_to_word();
		end
	endfunction

	// Builds a message with random address, tags and arguments; d_tail cuts it off inside its leading d.
	function automatic void build_message(bit many_tags, bit d_tail);
		logic [7:0] tag_seq[$];
		int         arg_start;
		int         keep;
		pkt.delete();
		add_byte(CH_SLASH);
		repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(1, 255)));
		add_byte(CH_NUL);
		pad_to_word();
		comma_at = pkt.size();
		add_byte(CH_COMMA);
		if (d_tail) begin
			tag_seq = {tag_seq, CH_D};
			case ($urandom_range(0, 2))
				0: tag_seq = {tag_seq, 8'h54};
				1: tag_seq = {tag_seq, CH_S};
				default: ;
			endcase
			tag_seq = {tag_seq, ($urandom_range(0, 1) ? CH_F : CH_I)};
		end else
			repeat (many_tags ? $urandom_range(33, 38) : $urandom_range(0, 5))
				tag_seq = {tag_seq, pick_tag()};
		foreach (tag_seq[k])
			add_byte(tag_seq[k]);
		add_byte(CH_NUL);
		pad_to_word();
		arg_start = pkt.size();
		foreach (tag_seq[k])
			if (k < MAX_TAGS)
				add_arg_data(tag_seq[k]);
		if (d_tail) begin
			keep = arg_start + $urandom_range(4, 7);
			while (pkt.size() > keep)
				void'(pkt.pop_back());
		end
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				result_ready <= 1'b0;
			end else
				result_ready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, result_item);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(result_item.kind));
				check_field("word", want.word, result_item.word);
				check_field("arg_is_int", 32'(want.arg_is_int), 32'(result_item.arg_is_int));
				check_field("arg_number", 32'(want.arg_number), 32'(result_item.arg_number));
				check_field("reject_reason", 32'(want.reject_reason),
					32'(result_item.reject_reason));
				check_field("run_last", 32'(want.run_last), 32'(result_item.run_last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && byte_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		byte_item_t it;
		int         sent;
		int         pkt_count;
		int         pick;
		int         cut;
		clear_parser();
		wait (arst_n);
		@(posedge clk);

		foreach (directed_rows[r]) begin
			it.data_byte  = directed_rows[r].data;
			it.final_byte = directed_rows[r].fin;
			send_byte(it, directed_rows[r].typed, directed_rows[r].want);
		end

		sent      = 0;
		pkt_count = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_on = (sent < RANDOM_ITEMS - 60) && ($urandom_range(0, 3) != 0);
			pick    = $urandom_range(0, 99);
			if (pkt_count == 2)
				build_message(1'b1, 1'b0);
			else if (pick < 10)
				build_message(1'b0, 1'b1);
			else begin
				build_message(1'b0, 1'b0);
				if (pick < 58)
					;
				else if (pick < 74) begin
					cut = $urandom_range(1, pkt.size());
					while (pkt.size() > cut)
						void'(pkt.pop_back());
				end else if (pick < 82)
					repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
				else if (pick < 88)
					pkt[comma_at] = any_but(CH_COMMA);
				else if (pick < 93)
					pkt[0] = any_but(CH_SLASH);
				else begin
					pkt.delete();
					repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
				end
			end
			sent += pkt.size();
			pkt_count++;
			send_packet();
		end
		byte_valid <= 1'b0;
		idle_on = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- osc_message_parser_core.f -----
hw/rtl/omp_pkg.sv
hw/rtl/omp_result_queue.sv
hw/rtl/omp_parse_engine.sv
hw/rtl/osc_message_parser_core.sv
tb/sv/testbench.sv
